/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the speaker tone block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

/* sv/pcs_pkg.sv */
// Package for the speaker square-wave block: field widths, operation codes
// and parameter defaults. No dependencies.
`default_nettype none

package pcs_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int DIV_W    = 16;
    localparam int RATE_W   = 18;
    localparam int SAMPLE_W = 15;

    // Phase and bound width, and the width of phase plus step
    localparam int PHASE_W  = 34;
    localparam int SUM_W    = PHASE_W + 1;

    // Parameter defaults
    localparam int PIT_RATE_DEF   = 1193182;
    localparam int HIGH_LEVEL_DEF = 24575;

    // Reset value of the sample rate register
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = RATE_W'(44100);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_TONE  = 2'd1,
        OP_CONST = 2'd2
    } op_t;

endpackage

`default_nettype wire

/* sv/pcs_cmd_if.sv */
// Command channel of the speaker square-wave block: valid/ready plus payload.
// Depends on pcs_pkg for field widths.
`default_nettype none

interface pcs_cmd_if
    import pcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [DIV_W-1:0]   inv_freq;
    logic               const_high;

    modport source (output valid, output operation, output inv_freq,
                    output const_high, input ready);
    modport sink   (input valid, input operation, input inv_freq,
                    input const_high, output ready);
endinterface

`default_nettype wire

/* sv/pcs_audio_if.sv */
// Audio sample channel of the speaker square-wave block: valid/ready plus sample.
// Depends on pcs_pkg for the sample width.
`default_nettype none

interface pcs_audio_if
    import pcs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* sv/pc_speaker_square_wave_gen_top.sv */
// Speaker square-wave generator: timer-divisor tone resampled to audio rate.
// Depends on pcs_pkg, pcs_cmd_if, pcs_audio_if and assert_macros.svh.
//
// Usage:
//   cmd carries requests: sample tick, start tone (inv_freq) or hold
//   constant level (const_high). audio carries one sample per tick,
//   0 or HIGH_LEVEL. cfg_wr_en/cfg_wr_data write sample_rate while idle.
// Timing:
//   Start tone, hold constant and ticks with no wrap leave the block idle; the
//   period bound product is formed in the accept cycle. A tick whose
//   phase plus step reaches a nonzero bound runs a restoring remainder,
//   one bit a cycle through a shared compare/subtract, over every dividend
//   bit; cmd.ready stays low meanwhile. The tick's sample is registered at
//   accept, so it shows on audio the cycle after the tick is taken.
// Stall:
//   The sample register holds a pending sample; cmd.ready is low while
//   that sample waits and audio.ready is low, then rises in the cycle the
//   sample is taken.
// Reset:
//   Constant-level mode, output low, phase and bound zero, sample_rate
//   44100, no sample pending.
`default_nettype none
`include "assert_macros.svh"

module pc_speaker_square_wave_gen_top
    import pcs_pkg::*;
#(
    parameter int PIT_RATE   = PIT_RATE_DEF,
    parameter int HIGH_LEVEL = HIGH_LEVEL_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [RATE_W-1:0] cfg_wr_data,
    pcs_cmd_if.sink                cmd,
    pcs_audio_if.source            audio
);

    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [SUM_W-1:0]    STEP     = SUM_W'(2 * PIT_RATE);
    localparam logic [SAMPLE_W-1:0] HIGH_VAL = SAMPLE_W'(HIGH_LEVEL);
    localparam logic [CNT_W-1:0]    LAST_CNT = CNT_W'(SUM_W - 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t                state_reg,       state_next;
    logic [RATE_W-1:0]     sample_rate_reg, sample_rate_next;
    logic                  tone_mode_reg,   tone_mode_next;
    logic                  level_reg,       level_next;
    logic [PHASE_W-1:0]    phase_reg,       phase_next;
    logic [PHASE_W-1:0]    bound_reg,       bound_next;
    logic [SUM_W-1:0]      dividend_reg,    dividend_next;
    logic [PHASE_W-1:0]    rem_reg,         rem_next;
    logic [CNT_W-1:0]      cnt_reg,         cnt_next;
    logic                  out_valid_reg,   out_valid_next;
    logic [SAMPLE_W-1:0]   sample_reg,      sample_next;

    logic                  accept;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      rem_shift;
    logic [SUM_W-1:0]      rem_diff;
    logic [SUM_W-1:0]      bound_ext;

    // Take a request when idle and the sample slot is free or draining
    assign cmd.ready   = (state_reg == ST_IDLE) && (!out_valid_reg || audio.ready);
    assign accept      = cmd.valid && cmd.ready;
    assign audio.valid = out_valid_reg;
    assign audio.sample = sample_reg;

    // Shared datapath: phase step, and one remainder step
    assign bound_ext = {1'b0, bound_reg};
    assign sum       = {1'b0, phase_reg} + STEP;
    assign rem_shift = {rem_reg, dividend_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - bound_ext;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        sample_rate_next = sample_rate_reg;
        tone_mode_next   = tone_mode_reg;
        level_next       = level_reg;
        phase_next       = phase_reg;
        bound_next       = bound_reg;
        dividend_next    = dividend_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !audio.ready;
        sample_next      = sample_reg;

        // Write the rate register
        if (cfg_wr_en)
        begin
            sample_rate_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(cmd.operation))
                        OP_TONE:
                        begin
                            tone_mode_next = 1'b1;
                            level_next     = 1'b0;
                            phase_next     = '0;
                            bound_next     = PHASE_W'(sample_rate_reg) * PHASE_W'(cmd.inv_freq);
                        end
                        OP_CONST:
                        begin
                            tone_mode_next = 1'b0;
                            level_next     = cmd.const_high;
                        end
                        OP_TICK:
                        begin
                            // Emit the current level, then advance the phase
                            out_valid_next = 1'b1;
                            sample_next    = level_reg ? HIGH_VAL : '0;
                            if (tone_mode_reg)
                            begin
                                if (bound_reg == '0)
                                begin
                                    phase_next = '0;
                                    level_next = !level_reg;
                                end
                                else if (sum >= bound_ext)
                                begin
                                    level_next    = !level_reg;
                                    dividend_next = sum;
                                    rem_next      = '0;
                                    cnt_next      = '0;
                                    state_next    = ST_DIV;
                                end
                                else
                                begin
                                    phase_next = sum[PHASE_W-1:0];
                                end
                            end
                        end
                        default:
                        begin
                            // Unused code: drop the request
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                // Shift in one dividend bit, subtract the bound when it fits
                dividend_next = dividend_reg << 1;
                if (rem_shift >= bound_ext)
                begin
                    rem_next = rem_diff[PHASE_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[PHASE_W-1:0];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    phase_next = rem_next;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sample_rate_reg <= SAMPLE_RATE_RST;
            tone_mode_reg   <= 1'b0;
            level_reg       <= 1'b0;
            phase_reg       <= '0;
            bound_reg       <= '0;
            dividend_reg    <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            sample_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sample_rate_reg <= sample_rate_next;
            tone_mode_reg   <= tone_mode_next;
            level_reg       <= level_next;
            phase_reg       <= phase_next;
            bound_reg       <= bound_next;
            dividend_reg    <= dividend_next;
            rem_reg         <= rem_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            sample_reg      <= sample_next;
        end
    end

    // Assertions
    `ASSERT_SAME(a_busy_not_ready, state_reg == ST_DIV, !cmd.ready)
    `ASSERT_SAME(a_phase_below_bound,
                 state_reg == ST_IDLE && tone_mode_reg && bound_reg != '0,
                 phase_reg < bound_reg)
    `ASSERT_NEXT(a_tick_gives_sample,
                 accept && cmd.operation == OP_TICK,
                 out_valid_reg)

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the speaker square-wave generator: random and directed
// requests against an internal predictor of tone phase, period bound and level.
// Depends on pcs_pkg, pcs_cmd_if, pcs_audio_if and pc_speaker_square_wave_gen_top.
`default_nettype none

module testbench;
    import pcs_pkg::*;

    localparam int PIT_RATE    = PIT_RATE_DEF;
    localparam int HIGH_LEVEL  = HIGH_LEVEL_DEF;
    localparam int RATE_MAX    = (1 << RATE_W) - 1;
    localparam int DRAIN_WAIT  = 48;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 75;

    // Code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Phase advance per sample tick
    localparam logic [SUM_W-1:0] PHASE_STEP = SUM_W'(2 * PIT_RATE);

    typedef struct {
        logic [OP_W-1:0]  operation;
        logic [DIV_W-1:0] inv_freq;
        logic             const_high;
        int               gap;
    } speaker_req_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [RATE_W-1:0] cfg_wr_data;

    pcs_cmd_if   cmd_ch ();
    pcs_audio_if audio_ch ();

    pc_speaker_square_wave_gen_top #(
        .PIT_RATE   (PIT_RATE),
        .HIGH_LEVEL (HIGH_LEVEL)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .audio       (audio_ch)
    );

    // Predicted speaker state
    logic [RATE_W-1:0]  rate_shadow;
    logic               tone_on;
    logic               level_on;
    logic [PHASE_W-1:0] tone_phase;
    logic [PHASE_W-1:0] tone_bound;

    speaker_req_t          req_queue[$];
    logic [SAMPLE_W-1:0]   due_samples[$];
    int                    fault_count;
    int                    hold_left;
    int                    stall_left;
    bit                    sink_steady;
    int                    cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_req(logic [OP_W-1:0] op, logic [DIV_W-1:0] div, logic hi,
                                      int gap);
        speaker_req_t r;
        r.operation  = op;
        r.inv_freq   = div;
        r.const_high = hi;
        r.gap        = gap;
        req_queue.push_back(r);
    endfunction

    // Apply one accepted request to the predicted state, queue the sample it emits
    function automatic void speaker_advance(logic [OP_W-1:0] op, logic [DIV_W-1:0] div,
                                            logic hi);
        logic [SUM_W-1:0] sum;
        case (op)
            OP_TONE:
            begin
                tone_on    = 1'b1;
                level_on   = 1'b0;
                tone_phase = '0;
                tone_bound = PHASE_W'(rate_shadow) * PHASE_W'(div);
            end
            OP_CONST:
            begin
                tone_on  = 1'b0;
                level_on = hi;
            end
            OP_TICK:
            begin
                due_samples.push_back(level_on ? SAMPLE_W'(HIGH_LEVEL) : '0);
                if (tone_on)
                begin
                    sum = SUM_W'(tone_phase) + PHASE_STEP;
                    if (tone_bound == '0)
                    begin
                        tone_phase = '0;
                        level_on   = ~level_on;
                    end
                    else if (sum >= SUM_W'(tone_bound))
                    begin
                        tone_phase = PHASE_W'(sum % SUM_W'(tone_bound));
                        level_on   = ~level_on;
                    end
                    else
                        tone_phase = PHASE_W'(sum);
                end
            end
            default: ;
        endcase
    endfunction

    // Request driver: predict on accept, then present the next queued request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                speaker_advance(cmd_ch.operation, cmd_ch.inv_freq, cmd_ch.const_high);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (hold_left > 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    hold_left--;
                end
                else if (req_queue.size() != 0)
                begin : present
                    speaker_req_t r;
                    r = req_queue.pop_front();
                    cmd_ch.operation  <= r.operation;
                    cmd_ch.inv_freq   <= r.inv_freq;
                    cmd_ch.const_high <= r.const_high;
                    cmd_ch.valid      <= 1'b1;
                    hold_left = r.gap;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Sample monitor: check against the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            audio_ch.ready <= 1'b0;
            stall_left = 0;
            sink_steady = 1'b0;
        end
        else
        begin
            if (audio_ch.valid && audio_ch.ready)
            begin : check
                logic [SAMPLE_W-1:0] want;
                if (due_samples.size() == 0)
                begin
                    $error("sample with no prediction waiting: actual %0d", audio_ch.sample);
                    fault_count++;
                end
                else
                begin
                    want = due_samples.pop_front();
                    if (audio_ch.sample !== want)
                    begin
                        $error("sample mismatch: expected %0d, actual %0d",
                               want, audio_ch.sample);
                        fault_count++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                sink_steady = ~sink_steady;
            if (stall_left == 0 && !sink_steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                audio_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                audio_ch.ready <= 1'b1;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Wait until every request is taken and every sample is back, then let the
    // remainder loop settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_queue.size() != 0 || cmd_ch.valid || due_samples.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Stimulus sequencer
    initial
    begin : stimulus
        int                rates[PHASES];
        int                made;
        int                n;
        logic [DIV_W-1:0]  div;
        longint            span;
        bit                calm;
        logic [OP_W-1:0]   op;
        logic [RATE_W-1:0] rate_pick;

        rates = '{1, RATE_MAX, 8000, 0, 48000, 0};
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_TICK;
        cmd_ch.inv_freq   = '0;
        cmd_ch.const_high = 1'b0;
        audio_ch.ready    = 1'b0;
        fault_count       = 0;
        cycle_count       = 0;
        rate_shadow       = SAMPLE_RATE_RST;
        tone_on           = 1'b0;
        level_on          = 1'b0;
        tone_phase        = '0;
        tone_bound        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: constant levels, ignored code, zero bound, wrap every tick
        queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_CONST, '0, 1'b1, pick_gap());
        queue_req(OP_TICK, '1, 1'b1, pick_gap());
        queue_req(OP_UNUSED, '1, 1'b1, pick_gap());
        queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_CONST, '1, 1'b0, pick_gap());
        queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_TONE, '0, 1'b0, pick_gap());
        repeat (3) queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_TONE, 16'd1, 1'b0, pick_gap());
        repeat (3) queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_CONST, '0, 1'b1, pick_gap());
        queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_TONE, '1, 1'b1, pick_gap());
        repeat (2) queue_req(OP_TICK, '0, 1'b0, pick_gap());
        queue_req(OP_UNUSED, '0, 1'b0, pick_gap());
        queue_req(OP_TICK, '0, 1'b0, pick_gap());
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            // Load the next sample rate while idle
            rate_pick = (rates[p] == 0) ? RATE_W'($urandom_range(1, RATE_MAX))
                                        : RATE_W'(rates[p]);
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= rate_pick;
            rate_shadow = rate_pick;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            @(negedge clk);

            // A bound past 32 bits must not wrap
            if (rates[p] == RATE_MAX)
            begin
                queue_req(OP_TONE, 16'd16385, 1'b0, pick_gap());
                repeat (3) queue_req(OP_TICK, '0, 1'b0, pick_gap());
            end

            made = 0;
            while (made < PHASE_ITEMS)
            begin
                calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 99) < 75)
                begin
                    // Tone followed by a run of ticks, now and then a held level
                    case ($urandom_range(0, 3))
                        0:       div = DIV_W'($urandom);
                        1:       div = DIV_W'($urandom_range(0, 15));
                        default:
                        begin
                            span = (4 * longint'(PHASE_STEP)) / rate_shadow + 1;
                            if (span > 65535)
                                span = 65535;
                            div = DIV_W'($urandom_range(0, int'(span)));
                        end
                    endcase
                    queue_req(OP_TONE, div, 1'(($urandom)), calm ? 0 : pick_gap());
                    n = $urandom_range(1, 24);
                    made += n + 1;
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            queue_req(OP_CONST, DIV_W'($urandom), 1'($urandom),
                                      calm ? 0 : pick_gap());
                            made++;
                        end
                        queue_req(OP_TICK, DIV_W'($urandom), 1'($urandom),
                                  calm ? 0 : pick_gap());
                    end
                end
                else
                begin
                    // Loose requests of any code
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                    begin
                        op = OP_W'($urandom_range(0, 3));
                        queue_req(op, DIV_W'($urandom), 1'($urandom), calm ? 0 : pick_gap());
                        if (op != OP_UNUSED)
                            made++;
                    end
                end
            end
            wait_drained();
        end

        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
